@@ rtl/core/fbd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbd_pkg
// Shared constants and decode functions for the FP4 block-scaled dequantizer.
// ----------------------------------------------------------------------------
package fbd_pkg;

  localparam int          PIPE_STAGES = 8;
  localparam logic [31:0] F32_QNAN  = 32'h7FC0_0000;
  localparam logic [31:0] F32_INF   = 32'h7F80_0000;
  localparam logic [15:0] BF16_QNAN = 16'h7FC0;
  localparam logic [31:0] GS_RESET  = 32'h3F80_0000;

  // E4M3 scale byte to the fp32 bit pattern of the same value.
  function automatic logic [31:0] decode_e4m3(input logic [7:0] code);
    logic       sgn;
    logic [3:0] ex;
    logic [2:0] man;
    logic [31:0] mag;
    sgn = code[7];
    ex  = code[6:3];
    man = code[2:0];
    if (ex == 4'hF && man == 3'h7) begin
      return F32_QNAN;
    end
    if (ex == 4'h0) begin
      // Subnormal codes are mant * 2^-9, which are normal in fp32.
      if (man[2]) begin
        mag = {1'b0, 8'd120, man[1:0], 21'd0};
      end else if (man[1]) begin
        mag = {1'b0, 8'd119, man[0], 22'd0};
      end else if (man[0]) begin
        mag = {1'b0, 8'd118, 23'd0};
      end else begin
        mag = 32'd0;
      end
    end else begin
      mag = {1'b0, 4'd0, ex, man, 20'd0} + {1'b0, 8'd120, 23'd0};
    end
    return {sgn, mag[30:0]};
  endfunction

  // E2M1 nibble to the fp32 bit pattern of its value.
  function automatic logic [31:0] decode_e2m1(input logic [3:0] nib);
    logic [30:0] mag;
    case (nib[2:0])
      3'd0:    mag = 31'h0000_0000;
      3'd1:    mag = 31'h3F00_0000;
      3'd2:    mag = 31'h3F80_0000;
      3'd3:    mag = 31'h3FC0_0000;
      3'd4:    mag = 31'h4000_0000;
      3'd5:    mag = 31'h4040_0000;
      3'd6:    mag = 31'h4080_0000;
      default: mag = 31'h40C0_0000;
    endcase
    return {nib[3], mag};
  endfunction

  // fp32 to bf16, round to nearest even, any NaN made canonical.
  function automatic logic [15:0] f32_to_bf16(input logic [31:0] b);
    logic [32:0] sum;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
      return BF16_QNAN;
    end
    sum = {1'b0, b} + 33'h0_7FFF + {32'd0, b[16]};
    return sum[31:16];
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/fbd_fmul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fbd_fmul
// Three-stage IEEE fp32 multiplier, round to nearest even, with subnormals.
// ----------------------------------------------------------------------------
module fbd_fmul (
  input  wire logic        clk,
  input  wire logic [2:0]  en,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [31:0] p
);

  // Stage A: unpack and significand product.
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;

  logic        sa_sgn, sa_nan, sa_inf;
  logic [8:0]  sa_esum;
  logic [47:0] sa_prod;

  always_comb begin
    a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sa_sgn  <= a[31] ^ b[31];
      sa_nan  <= a_nan | b_nan | (a_inf & b_zero) | (b_inf & a_zero);
      sa_inf  <= a_inf | b_inf;
      sa_esum <= {1'b0, ea} + {1'b0, eb};
      sa_prod <= ma * mb;
    end
  end

  // Stage B: leading one, shift amount and result exponent.
  logic [5:0]        lead;
  logic signed [10:0] sh_norm, sh_sub, rsh, s_full, e_m1;
  logic              normal;

  logic        sb_sgn, sb_nan, sb_inf, sb_zero;
  logic [6:0]  sb_shift;
  logic [9:0]  sb_ebits;
  logic [47:0] sb_prod;

  always_comb begin
    lead = 6'd0;
    for (int i = 0; i < 48; i++) begin
      if (sa_prod[i]) begin
        lead = 6'(i);
      end
    end
    sh_norm = $signed({5'd0, lead}) - 11'sd23;
    sh_sub  = 11'sd151 - $signed({2'd0, sa_esum});
    normal  = (sh_norm >= sh_sub);
    rsh     = normal ? sh_norm : sh_sub;
    s_full  = rsh + 11'sd24;
    e_m1    = $signed({2'd0, sa_esum}) + $signed({5'd0, lead}) - 11'sd174;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sb_sgn   <= sa_sgn;
      sb_nan   <= sa_nan;
      sb_inf   <= sa_inf;
      sb_zero  <= (sa_prod == 48'd0);
      sb_shift <= (s_full > 11'sd73) ? 7'd73 : s_full[6:0];
      sb_ebits <= normal ? e_m1[9:0] : 10'd0;
      sb_prod  <= sa_prod;
    end
  end

  // Stage C: align, round and pack.
  logic [73:0] q, mant, lost, half, mask;
  logic        inc;
  logic [33:0] packed_sum;
  logic [31:0] res;

  always_comb begin
    q    = {2'd0, sb_prod, 24'd0};
    mant = q >> sb_shift;
    mask = (74'd1 << sb_shift) - 74'd1;
    half = 74'd1 << (sb_shift - 7'd1);
    lost = q & mask;
    inc  = (lost > half) || ((lost == half) && mant[0]);
    packed_sum = {1'b0, sb_ebits, 23'd0} + {9'd0, mant[24:0]} + {33'd0, inc};
    if (sb_nan) begin
      res = fbd_pkg::F32_QNAN;
    end else if (sb_inf || packed_sum >= {2'd0, fbd_pkg::F32_INF}) begin
      res = {sb_sgn, fbd_pkg::F32_INF[30:0]};
    end else if (sb_zero) begin
      res = {sb_sgn, 31'd0};
    end else begin
      res = {sb_sgn, packed_sum[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      p <= res;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/fp4_block_scaled_dequant_to_bf16_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// fp4_block_scaled_dequant_to_bf16_top
// Dequantizes pairs of E2M1 weights with an E4M3 group scale and an fp32
// global scale into two bf16 values per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input requests arrive on s_axis: tdata holds the scale byte and the packed
//   weight byte, tlast marks the final byte of the tensor. Each request gives
//   one output request on m_axis with the even and odd bf16 values and a copy
//   of tlast. The global scale is written through cfg_we/cfg_wdata while no
//   request is in flight; it resets to 1.0.
//   The datapath is an eight-stage pipeline: input decode, three stages of
//   the scale multiplier, three stages of the two weight multipliers, and the
//   bf16 rounding output register. One request is accepted every cycle
//   while the output is not stalled.
//   Each stage has its own valid bit and advances when the stage after it is
//   empty or moving, so a stalled receiver holds the results in place while
//   empty stages ahead of them still fill. Reset clears all valid bits.
// ----------------------------------------------------------------------------
module fp4_block_scaled_dequant_to_bf16_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // scale_code [7:0], packed_pair [15:8]
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,   // even_value_bf16 [15:0], odd_value_bf16 [31:16]
  output logic             m_axis_tlast
);

  logic [31:0]                     tensor_scale;
  logic [fbd_pkg::PIPE_STAGES-1:0] v, en;

  logic [31:0] scale_f32;
  logic [31:0] w_even [0:3];
  logic [31:0] w_odd  [0:3];
  logic        last_q [0:fbd_pkg::PIPE_STAGES-1];
  logic [31:0] blk_scale, p_even, p_odd;

  always_comb begin
    en[fbd_pkg::PIPE_STAGES-1] = !v[fbd_pkg::PIPE_STAGES-1] || m_axis_tready;
    for (int i = fbd_pkg::PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      tensor_scale <= fbd_pkg::GS_RESET;
      v            <= '0;
    end else begin
      if (cfg_we) begin
        tensor_scale <= cfg_wdata;
      end
      if (en[0]) begin
        v[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < fbd_pkg::PIPE_STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Side data that travels alongside the multiplier stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      scale_f32 <= fbd_pkg::decode_e4m3(s_axis_tdata[7:0]);
      w_even[0] <= fbd_pkg::decode_e2m1(s_axis_tdata[11:8]);
      w_odd[0]  <= fbd_pkg::decode_e2m1(s_axis_tdata[15:12]);
      last_q[0] <= s_axis_tlast;
    end
    for (int i = 1; i < 4; i++) begin
      if (en[i]) begin
        w_even[i] <= w_even[i-1];
        w_odd[i]  <= w_odd[i-1];
      end
    end
    for (int i = 1; i < fbd_pkg::PIPE_STAGES; i++) begin
      if (en[i]) begin
        last_q[i] <= last_q[i-1];
      end
    end
  end

  fbd_fmul u_scale_mul (
    .clk (clk),
    .en  (en[3:1]),
    .a   (scale_f32),
    .b   (tensor_scale),
    .p   (blk_scale)
  );

  fbd_fmul u_even_mul (
    .clk (clk),
    .en  (en[6:4]),
    .a   (w_even[3]),
    .b   (blk_scale),
    .p   (p_even)
  );

  fbd_fmul u_odd_mul (
    .clk (clk),
    .en  (en[6:4]),
    .a   (w_odd[3]),
    .b   (blk_scale),
    .p   (p_odd)
  );

  always_ff @(posedge clk) begin
    if (en[fbd_pkg::PIPE_STAGES-1]) begin
      m_axis_tdata <= {fbd_pkg::f32_to_bf16(p_odd), fbd_pkg::f32_to_bf16(p_even)};
    end
  end

  assign m_axis_tvalid = v[fbd_pkg::PIPE_STAGES-1];
  assign m_axis_tlast  = last_q[fbd_pkg::PIPE_STAGES-1];

endmodule
`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// FP4 block-scaled dequantizer testbench
// Streams scale and weight bytes through the dequantizer under several global
// scales and compares every bf16 pair against a bit-exact software predictor.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] scale_code;
    logic [7:0] packed_pair;
    logic       last;
  } weight_req_t;

  typedef struct packed {
    logic [15:0] even_bf16;
    logic [15:0] odd_bf16;
    logic        last;
  } bf16_pair_t;

  localparam int LATENCY     = fbd_pkg::PIPE_STAGES;
  localparam int CYCLE_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tlast;

  weight_req_t pending_reqs[$];
  bf16_pair_t  expected_pairs[$];
  logic [31:0] tensor_scale;
  int          error_count;
  int          cycle_count;
  int          send_gap;
  int          stall_left;
  bit          no_idle;

  real e2m1_mag[8] = '{0.0, 0.5, 1.0, 1.5, 2.0, 3.0, 4.0, 6.0};

  fp4_block_scaled_dequant_to_bf16_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // fp32 bits to a double; every fp32 value is exact in a double.
  function automatic real f32_to_real(logic [31:0] b);
    logic [63:0] d;
    real         v;
    if (b[30:23] == 8'hFF) begin
      if (b[22:0] != 23'd0) begin
        return $bitstoreal(64'h7FF8_0000_0000_0000);
      end
      return $bitstoreal({b[31], 63'h7FF0_0000_0000_0000});
    end
    if (b[30:23] == 8'h00) begin
      v = real'(b[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
      return b[31] ? -v : v;
    end
    d = {b[31], 11'(b[30:23]) + 11'd896, b[22:0], 29'd0};
    return $bitstoreal(d);
  endfunction

  // Double to fp32 with round to nearest even, including subnormal results.
  function automatic logic [31:0] real_to_f32(real r);
    logic [63:0] d;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] mag;
    int          e;
    int          sh;
    d = $realtobits(r);
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 52'd0) ? 32'h7FC0_0000 : {d[63], 31'h7F80_0000};
    end
    if (d[62:52] == 11'h000) begin
      return {d[63], 31'd0};
    end
    e = int'(d[62:52]) - 1023;
    m = {11'd0, 1'b1, d[51:0]};
    sh = (e >= -126) ? 29 : 29 + (-126 - e);
    if (sh > 60) begin
      return {d[63], 31'd0};
    end
    q    = m >> sh;
    rem  = m & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 64'd1;
    end
    // The hidden bit in q carries into the exponent field on its own.
    mag = (e >= -126) ? (64'(e + 126) << 23) + q : q;
    if (mag >= 64'h7F80_0000) begin
      mag = 64'h7F80_0000;
    end
    return {d[63], mag[30:0]};
  endfunction

  function automatic real e4m3_to_real(logic [7:0] code);
    real v;
    if (code[6:0] == 7'h7F) begin
      return $bitstoreal(64'h7FF8_0000_0000_0000);
    end
    if (code[6:3] == 4'h0) begin
      v = real'(code[2:0]) / 512.0;
    end else begin
      v = f32_to_real({1'b0, 8'(code[6:3]) + 8'd120, code[2:0], 20'd0});
    end
    return code[7] ? -v : v;
  endfunction

  function automatic logic [15:0] round_to_bf16(logic [31:0] b);
    logic [32:0] sum;
    if (b[30:23] == 8'hFF && b[22:0] != 23'd0) begin
      return 16'h7FC0;
    end
    sum = {1'b0, b} + 33'h7FFF + {32'd0, b[16]};
    return sum[31:16];
  endfunction

  function automatic logic [15:0] dequant_weight(logic [3:0] nib, logic [31:0] grp);
    real w;
    w = e2m1_mag[nib[2:0]];
    if (nib[3]) begin
      w = -w;
    end
    return round_to_bf16(real_to_f32(w * f32_to_real(grp)));
  endfunction

  function automatic bf16_pair_t dequant_pair(weight_req_t req, logic [31:0] gs);
    bf16_pair_t  res;
    logic [31:0] grp;
    grp = real_to_f32(e4m3_to_real(req.scale_code) * f32_to_real(gs));
    res.even_bf16 = dequant_weight(req.packed_pair[3:0], grp);
    res.odd_bf16  = dequant_weight(req.packed_pair[7:4], grp);
    res.last      = req.last;
    return res;
  endfunction

  function automatic int random_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) begin
      return 0;
    end
    if (pick < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 40);
  endfunction

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tlast  <= 1'b0;
      send_gap      <= 0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap      <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        weight_req_t req;
        req = pending_reqs.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {req.packed_pair, req.scale_code};
        s_axis_tlast  <= req.last;
        send_gap      <= random_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left    <= random_gap();
    end
  end

  // Monitor: predict on accepted inputs, check accepted outputs.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        weight_req_t req;
        req.scale_code  = s_axis_tdata[7:0];
        req.packed_pair = s_axis_tdata[15:8];
        req.last        = s_axis_tlast;
        expected_pairs.push_back(dequant_pair(req, tensor_scale));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        bf16_pair_t got;
        bf16_pair_t want;
        got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast};
        if (expected_pairs.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          error_count++;
        end else begin
          want = expected_pairs.pop_front();
          if (got.even_bf16 != want.even_bf16) begin
            $display("%0t: even expected %h actual %h", $time, want.even_bf16,
                     got.even_bf16);
            error_count++;
          end
          if (got.odd_bf16 != want.odd_bf16) begin
            $display("%0t: odd expected %h actual %h", $time, want.odd_bf16,
                     got.odd_bf16);
            error_count++;
          end
          if (got.last != want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, got.last);
            error_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  task automatic queue_req(logic [7:0] sc, logic [7:0] pk, logic lst);
    pending_reqs.push_back('{sc, pk, lst});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid || expected_pairs.size() > 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tensor_scale(logic [31:0] value);
    @(posedge clk);
    cfg_we       <= 1'b1;
    cfg_wdata    <= value;
    tensor_scale <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [31:0] scales[$];
    logic [7:0]  directed_codes[$];
    logic [31:0] gs;
    int          i;
    cycle_count   = 0;
    error_count   = 0;
    no_idle       = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    tensor_scale  = fbd_pkg::GS_RESET;
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Scale extremes, subnormals, signed zero and both NaN codes, with every
    // nibble value on both halves of the pair.
    directed_codes = '{8'h00, 8'h01, 8'h04, 8'h07, 8'h08, 8'h38, 8'h7E, 8'h7F,
                       8'h80, 8'h81, 8'h87, 8'hB8, 8'hFE, 8'hFF, 8'h3F, 8'h40};
    for (i = 0; i < directed_codes.size(); i++) begin
      queue_req(directed_codes[i], {4'(15 - i), 4'(i)}, i == directed_codes.size() - 1);
    end
    queue_req(8'h38, 8'h80, 1'b0);
    queue_req(8'h38, 8'h08, 1'b1);
    queue_req(8'hFE, 8'h77, 1'b0);
    queue_req(8'h7E, 8'hFF, 1'b1);
    wait_drained();

    scales = '{32'h0000_0000, 32'h8000_0000, 32'h7F7F_FFFF, 32'h0000_0001,
               32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0001, 32'hFFFF_FFFF,
               32'h007F_FFFF, 32'h4380_0000, 32'h3B80_0000};
    for (i = 0; i < 11; i++) begin
      if ($urandom_range(0, 1) == 0) begin
        scales.push_back($urandom());
      end else begin
        scales.push_back({1'($urandom()), 8'($urandom_range(90, 160)), 23'($urandom())});
      end
    end
    scales.push_back(fbd_pkg::GS_RESET);

    foreach (scales[p]) begin
      no_idle = ($urandom_range(0, 3) == 0);
      gs = scales[p];
      write_tensor_scale(gs);
      for (i = 0; i < 52; i++) begin
        queue_req(8'($urandom()), 8'($urandom()), $urandom_range(0, 15) == 0);
      end
      wait_drained();
    end

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fbd_pkg.sv
rtl/core/fbd_fmul.sv
rtl/core/fp4_block_scaled_dequant_to_bf16_top.sv
bench/testbench.sv
